/* sv/rgbr_pkg.sv */
package rgbr_pkg;

	// field widths fixed by the stream format
	localparam int PIX_W      = 16;
	localparam int SRC_W      = 10;
	localparam int DST_W      = 8;
	localparam int OFF_W      = 16;
	localparam int CODE_W     = 32;
	localparam int NCHAN      = 3;
	localparam int TDATA_W    = OFF_W + NCHAN * CODE_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// divider: numerator k*d + s - 1 stays below 2^19
	localparam int NUM_W     = 19;
	localparam int DIV_STEPS = NUM_W;
	localparam int DCNT_W    = 5;

	localparam int RESULT_CAP = 64;
	localparam int RCNT_W     = 6;

	localparam int MAX_DST_W    = 128;
	localparam int MAX_DST_H    = 128;
	localparam int MAX_CHANNELS = 3;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = 10'd320;
	localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = 10'd240;
	localparam logic [DST_W-1:0] DST_WIDTH_RST  = 8'd128;
	localparam logic [DST_W-1:0] DST_HEIGHT_RST = 8'd128;
	localparam logic [1:0]       DST_CHAN_RST   = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_DST_CHAN   = 3'd4,
		REG_OUT_MODE   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_INT8 = 2'd0,
		MODE_UNIT = 2'd1,
		MODE_SYM  = 2'd2,
		MODE_SYM3 = 2'd3
	} out_mode_t;

	typedef struct packed {
		logic [SRC_W-1:0] src_width;
		logic [SRC_W-1:0] src_height;
		logic [DST_W-1:0] dst_width;
		logic [DST_W-1:0] dst_height;
		logic [1:0]       dst_channels;
		out_mode_t        out_mode;
	} cfg_t;

	// one pixel's work: output row/column ranges [lo,hi) and formatted codes
	typedef struct packed {
		logic [DST_W-1:0]             row_lo;
		logic [DST_W-1:0]             row_hi;
		logic [DST_W-1:0]             col_lo;
		logic [DST_W-1:0]             col_hi;
		logic [NCHAN-1:0][CODE_W-1:0] code;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_LOAD,
		F_WAIT,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROW,
		B_EMIT
	} back_state_t;

	typedef logic [7:0]        exp5_tbl_t [32];
	typedef logic [7:0]        exp6_tbl_t [64];
	typedef logic [CODE_W-1:0] fmt_tbl_t  [256];

	function automatic exp5_tbl_t build_exp5();
		exp5_tbl_t t;
		for (int v = 0; v < 32; v++) begin
			t[v] = 8'((v * 255) / 31);
		end
		return t;
	endfunction

	function automatic exp6_tbl_t build_exp6();
		exp6_tbl_t t;
		for (int v = 0; v < 64; v++) begin
			t[v] = 8'((v * 255) / 63);
		end
		return t;
	endfunction

	// correctly rounded single of num/den, ties to even; long division by bits
	function automatic logic [31:0] f32_bits(logic sgn, longint unsigned num,
			longint unsigned den);
		longint unsigned n;
		longint unsigned d;
		int              e;
		logic [24:0]     m;
		logic            b;
		n = num;
		d = den;
		e = 0;
		m = '0;
		if (num == 0) begin
			return {sgn, 31'd0};
		end
		for (int i = 0; i < 80 && n < d; i++) begin
			n = n << 1;
			e = e - 1;
		end
		for (int i = 0; i < 80 && n >= (d << 1); i++) begin
			d = d << 1;
			e = e + 1;
		end
		for (int i = 0; i < 24; i++) begin
			b = (n >= d);
			m = {m[23:0], b};
			if (b) begin
				n = n - d;
			end
			n = n << 1;
		end
		if (n > d || (n == d && m[0])) begin
			m = m + 25'd1;
		end
		if (m[24]) begin
			m = 25'h0800000;
			e = e + 1;
		end
		return {sgn, 8'(127 + e), m[22:0]};
	endfunction

	function automatic fmt_tbl_t build_unit();
		fmt_tbl_t t;
		for (int v = 0; v < 256; v++) begin
			t[v] = f32_bits(1'b0, longint'(v), 64'd255);
		end
		return t;
	endfunction

	// v/127.5 rounded to single, then minus one rounded again
	function automatic fmt_tbl_t build_sym();
		fmt_tbl_t    t;
		logic [31:0] b1;
		int          e1;
		int          sh;
		longint      m1;
		longint      dif;
		for (int v = 0; v < 256; v++) begin
			if (v == 0) begin
				t[v] = 32'hBF800000;
			end else begin
				b1  = f32_bits(1'b0, longint'(2 * v), 64'd255);
				e1  = int'(b1[30:23]) - 127;
				sh  = 23 - e1;
				m1  = longint'({1'b1, b1[22:0]});
				dif = m1 - (longint'(1) << sh);
				if (dif < 0) begin
					t[v] = f32_bits(1'b1, longint'(-dif), longint'(1) << sh);
				end else begin
					t[v] = f32_bits(1'b0, longint'(dif), longint'(1) << sh);
				end
			end
		end
		return t;
	endfunction

	localparam exp5_tbl_t EXP5_TBL = build_exp5();
	localparam exp6_tbl_t EXP6_TBL = build_exp6();
	localparam fmt_tbl_t  UNIT_TBL = build_unit();
	localparam fmt_tbl_t  SYM_TBL  = build_sym();

endpackage

/* sv/rgbr_div.sv */
module rgbr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [rgbr_pkg::NUM_W-1:0]         num,
	input  logic [rgbr_pkg::SRC_W-1:0]         den,
	output logic                               done,
	output logic [rgbr_pkg::NUM_W-1:0]         quo
);

	// restoring divider, one quotient bit per cycle
	logic [rgbr_pkg::NUM_W-1:0]  sh_q;
	logic [rgbr_pkg::SRC_W-1:0]  rem_q;
	logic [rgbr_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rgbr_pkg::SRC_W:0]    trial;
	logic                        ge;

	assign trial = {rem_q, sh_q[rgbr_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == rgbr_pkg::DCNT_W'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rgbr_pkg::DCNT_W'(rgbr_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - rgbr_pkg::DCNT_W'(1);
				if (cnt_q == rgbr_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rgbr_pkg::SRC_W'(trial - {1'b0, den})
				: rgbr_pkg::SRC_W'(trial);
			sh_q  <= {sh_q[rgbr_pkg::NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

/* sv/rgbr_front.sv */
module rgbr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rgbr_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rgbr_pkg::PIX_W-1:0]   pixel,
	input  logic                         frame_start,
	output logic                         push,
	output rgbr_pkg::job_t               job,
	input  logic                         full
);

	rgbr_pkg::front_state_t state_q, state_d;

	logic [rgbr_pkg::SRC_W-1:0] col_q, row_q;
	logic [rgbr_pkg::SRC_W-1:0] kcol_q, krow_q;
	logic [1:0]                 sel_q;
	logic                       active_q;
	logic [rgbr_pkg::DST_W-1:0] bound_q [4];
	logic [rgbr_pkg::NCHAN-1:0][rgbr_pkg::CODE_W-1:0] code_q;

	logic [rgbr_pkg::SRC_W-1:0] col_use, row_use;
	logic                       col_wrap, row_wrap, accept, active;
	logic [rgbr_pkg::SRC_W:0]   k;
	logic [rgbr_pkg::DST_W-1:0] d;
	logic [rgbr_pkg::SRC_W-1:0] s;
	logic [rgbr_pkg::NUM_W-1:0] prod, num;
	logic                       div_start, div_done;
	logic [rgbr_pkg::NUM_W-1:0] quo;
	logic [rgbr_pkg::DST_W-1:0] q_clamped;
	logic [7:0]                 chan8 [rgbr_pkg::NCHAN];
	logic [rgbr_pkg::NCHAN-1:0][rgbr_pkg::CODE_W-1:0] code_d;
	logic [1:0]                 nch;

	assign accept  = in_valid && in_ready;
	assign col_use = frame_start ? '0 : col_q;
	assign row_use = frame_start ? '0 : row_q;
	assign col_wrap = ({1'b0, col_use} + 11'd1 >= {1'b0, cfg.src_width})
		|| col_use == '1;
	assign row_wrap = ({1'b0, row_use} + 11'd1 >= {1'b0, cfg.src_height})
		|| row_use == '1;
	assign active = cfg.src_width != '0 && cfg.src_height != '0
		&& cfg.dst_width != '0 && cfg.dst_height != '0;

	// channel expansion and formatting
	assign chan8[0] = rgbr_pkg::EXP5_TBL[pixel[15:11]];
	assign chan8[1] = rgbr_pkg::EXP6_TBL[pixel[10:5]];
	assign chan8[2] = rgbr_pkg::EXP5_TBL[pixel[4:0]];
	assign nch = (cfg.dst_channels > 2'(rgbr_pkg::MAX_CHANNELS))
		? 2'(rgbr_pkg::MAX_CHANNELS) : cfg.dst_channels;

	always_comb begin
		for (int c = 0; c < rgbr_pkg::NCHAN; c++) begin
			if (2'(c) >= nch) begin
				code_d[c] = '0;
			end else begin
				case (cfg.out_mode)
					rgbr_pkg::MODE_INT8: code_d[c] = {24'd0, chan8[c] ^ 8'h80};
					rgbr_pkg::MODE_UNIT: code_d[c] = rgbr_pkg::UNIT_TBL[chan8[c]];
					default:             code_d[c] = rgbr_pkg::SYM_TBL[chan8[c]];
				endcase
			end
		end
	end

	// sampling bound operands: col, col+1, row, row+1
	always_comb begin
		case (sel_q)
			2'd0:    k = {1'b0, kcol_q};
			2'd1:    k = {1'b0, kcol_q} + 11'd1;
			2'd2:    k = {1'b0, krow_q};
			default: k = {1'b0, krow_q} + 11'd1;
		endcase
		d = sel_q[1] ? cfg.dst_height : cfg.dst_width;
		s = sel_q[1] ? cfg.src_height : cfg.src_width;
	end

	assign prod = {8'd0, k} * {11'd0, d};
	assign num  = prod + {9'd0, s} - rgbr_pkg::NUM_W'(1);
	assign q_clamped = (quo > {11'd0, d}) ? d : quo[rgbr_pkg::DST_W-1:0];
	assign div_start = state_q == rgbr_pkg::F_LOAD;

	rgbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (s),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbr_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			rgbr_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = active ? rgbr_pkg::F_LOAD : rgbr_pkg::F_PUSH;
				end
			end
			rgbr_pkg::F_LOAD: begin
				state_d = rgbr_pkg::F_WAIT;
			end
			rgbr_pkg::F_WAIT: begin
				if (div_done) begin
					state_d = (sel_q == 2'd3) ? rgbr_pkg::F_PUSH : rgbr_pkg::F_LOAD;
				end
			end
			rgbr_pkg::F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = rgbr_pkg::F_IDLE;
				end
			end
			default: state_d = rgbr_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sel_q <= '0;
		end else begin
			if (accept) begin
				sel_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_use + 10'd1;
				end else begin
					col_q <= col_use + 10'd1;
					row_q <= row_use;
				end
			end else if (state_q == rgbr_pkg::F_WAIT && div_done) begin
				sel_q <= sel_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kcol_q   <= col_use;
			krow_q   <= row_use;
			active_q <= active;
			code_q   <= code_d;
		end
		if (state_q == rgbr_pkg::F_WAIT && div_done) begin
			bound_q[sel_q] <= q_clamped;
		end
	end

	always_comb begin
		job.code = code_q;
		if (active_q) begin
			job.col_lo = bound_q[0];
			job.col_hi = bound_q[1];
			job.row_lo = bound_q[2];
			job.row_hi = bound_q[3];
		end else begin
			job.col_lo = '0;
			job.col_hi = '0;
			job.row_lo = '0;
			job.row_hi = '0;
		end
	end

endmodule

/* sv/rgbr_fifo.sv */
module rgbr_fifo #(
	parameter int DEPTH = rgbr_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rgbr_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output rgbr_pkg::job_t rd_job,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rgbr_pkg::job_t mem [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	assign full   = cnt_q == CW'(DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr_job;
		end
	end

endmodule

/* sv/rgbr_back.sv */
module rgbr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rgbr_pkg::cfg_t                 cfg,
	input  rgbr_pkg::job_t                 job,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rgbr_pkg::TDATA_W-1:0]   out_data,
	output logic                           out_last
);

	rgbr_pkg::back_state_t state_q, state_d;

	rgbr_pkg::job_t              job_q;
	logic [rgbr_pkg::DST_W-1:0]  oy_q, ox_q;
	logic [rgbr_pkg::OFF_W-1:0]  idx_q;
	logic [rgbr_pkg::RCNT_W-1:0] n_q;
	logic                        valid_q;
	logic [rgbr_pkg::TDATA_W-1:0] data_q;
	logic                        last_q;

	logic slot_free, emit, col_end, row_end, last_res, has_work;
	logic [rgbr_pkg::OFF_W-1:0] offset;
	logic [rgbr_pkg::OFF_W-1:0] row_base;

	assign slot_free = !valid_q || out_ready;
	assign has_work  = job.row_lo < job.row_hi && job.col_lo < job.col_hi;
	assign col_end   = {1'b0, ox_q} + 9'd1 == {1'b0, job_q.col_hi};
	assign row_end   = {1'b0, oy_q} + 9'd1 == {1'b0, job_q.row_hi};
	assign last_res  = (col_end && row_end) || n_q == rgbr_pkg::RCNT_W'(rgbr_pkg::RESULT_CAP - 1);
	assign emit      = state_q == rgbr_pkg::B_EMIT && slot_free;
	assign offset    = rgbr_pkg::OFF_W'(idx_q * {14'd0, cfg.dst_channels});
	assign row_base  = {8'd0, oy_q} * {8'd0, cfg.dst_width} + {8'd0, job_q.col_lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbr_pkg::B_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			rgbr_pkg::B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (has_work) begin
						state_d = rgbr_pkg::B_ROW;
					end
				end
			end
			rgbr_pkg::B_ROW: begin
				state_d = rgbr_pkg::B_EMIT;
			end
			rgbr_pkg::B_EMIT: begin
				if (slot_free) begin
					if (last_res) begin
						state_d = rgbr_pkg::B_IDLE;
					end else if (col_end) begin
						state_d = rgbr_pkg::B_ROW;
					end
				end
			end
			default: state_d = rgbr_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
			oy_q  <= job.row_lo;
			n_q   <= '0;
		end
		if (state_q == rgbr_pkg::B_ROW) begin
			idx_q <= row_base;
			ox_q  <= job_q.col_lo;
		end
		if (emit) begin
			data_q <= {job_q.code[2], job_q.code[1], job_q.code[0], offset};
			last_q <= last_res;
			n_q    <= n_q + rgbr_pkg::RCNT_W'(1);
			if (col_end) begin
				oy_q <= oy_q + 8'd1;
			end else begin
				ox_q  <= ox_q + 8'd1;
				idx_q <= idx_q + 16'd1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

endmodule

/* sv/rgb565_resize_to_tensor.sv */
// Channel  Dir  Beat                               Accepted when
// s_axis   in   pixel, frame_start (tuser)         s_tvalid && s_tready
// m_axis   out  offset + three channel codes, tlast m_tvalid && m_tready
// cfg      in   register index, write data         cfg_we
//
// In the front, four sampling bounds (column start/end, row start/end)
// share one restoring divider, one bit a cycle. With a zero frame size
// the front skips the divider and pushes a job with empty ranges.
// The back pops a job, then sets up each output row in B_ROW and emits
// that row's result beats while m_tready is high.
// Reset clears position counters, queue and output valid; registers take
// their reset values. m_tready low holds the back; a full queue holds the front.
module rgb565_resize_to_tensor #(
	parameter int QUEUE_DEPTH = rgbr_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [rgbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgbr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// source pixels
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rgbr_pkg::PIX_W-1:0]         s_tdata,  // [15:0] pixel
	input  logic                               s_tuser,  // frame_start
	// tensor elements
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] dst_offset, [47:16] chan_red, [79:48] chan_green, [111:80] chan_blue
	output logic [rgbr_pkg::TDATA_W-1:0]       m_tdata,
	output logic                               m_tlast   // run_last
);

	rgbr_pkg::cfg_t cfg_q;
	rgbr_pkg::job_t push_job, pop_job;
	logic           push, pop, full, empty;

	// register file; unused indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width    <= rgbr_pkg::SRC_WIDTH_RST;
			cfg_q.src_height   <= rgbr_pkg::SRC_HEIGHT_RST;
			cfg_q.dst_width    <= rgbr_pkg::DST_WIDTH_RST;
			cfg_q.dst_height   <= rgbr_pkg::DST_HEIGHT_RST;
			cfg_q.dst_channels <= rgbr_pkg::DST_CHAN_RST;
			cfg_q.out_mode     <= rgbr_pkg::MODE_INT8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbr_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_wdata;
				rgbr_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_wdata;
				rgbr_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_wdata[7:0];
				rgbr_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_wdata[7:0];
				rgbr_pkg::REG_DST_CHAN:   cfg_q.dst_channels <= cfg_wdata[1:0];
				rgbr_pkg::REG_OUT_MODE:
					cfg_q.out_mode <= rgbr_pkg::out_mode_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	// front: position tracking, sampling bounds, channel codes
	rgbr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pixel       (s_tdata),
		.frame_start (s_tuser),
		.push        (push),
		.job         (push_job),
		.full        (full)
	);

	rgbr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.full   (full),
		.pop    (pop),
		.rd_job (pop_job),
		.empty  (empty)
	);

	// back: walks the output rectangle, one beat per cycle within a row while m_tready is high
	rgbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (pop_job),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

/* tb/rgb565_resize_to_tensor_tb.sv */
`timescale 1ns/1ps
`default_nettype none

// Streams RGB565 pixels into the resizer under several register settings and
// checks every tensor element beat against a local nearest-neighbour predictor
// (sampling ranges, 5/6-to-8-bit expansion, int8 and float formats).
module rgb565_resize_to_tensor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000; // cycles with no beat on either side
	localparam int SETTLE_CYCLES  = 150;   // wait after a drain so the front can finish a pixel
	localparam int ELEM_CAP       = 64;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pixel_beat_t;

	typedef struct {
		logic [OFF_W-1:0]  offset;
		logic [CODE_W-1:0] red;
		logic [CODE_W-1:0] green;
		logic [CODE_W-1:0] blue;
		logic              last;
	} tensor_elem_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;  // [15:0] pixel
	logic                  s_tuser;  // frame_start
	logic                  m_tvalid;
	logic                  m_tready;
	// [15:0] dst_offset, [47:16] chan_red, [79:48] chan_green, [111:80] chan_blue
	logic [TDATA_W-1:0]    m_tdata;
	logic                  m_tlast;  // run_last

	rgb565_resize_to_tensor dut (.*);

	// pending pixels and the elements they should produce
	pixel_beat_t  pixel_q[$];
	tensor_elem_t elem_q[$];

	int unsigned n_errors;
	int unsigned stall_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// local copy of the registers and the source position
	int unsigned src_w, src_h, dst_w, dst_h, n_chan;
	int unsigned mode;
	int unsigned cur_col, cur_row;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		n_errors++;
	endtask

	// nearest single of num/den, ties to even; num, den > 0 and small
	function automatic logic [31:0] single_of(input logic sgn, input longint unsigned num,
			input longint unsigned den);
		longint unsigned n, d, q, r;
		int              e;
		if (num == 0) begin
			return {sgn, 31'd0};
		end
		n = num;
		d = den;
		e = 0;
		while (n < d) begin
			n = n << 1;
			e--;
		end
		while (n >= (d << 1)) begin
			d = d << 1;
			e++;
		end
		q = (n << 23) / d;
		r = (n << 23) % d;
		if (2 * r > d || (2 * r == d && q[0])) begin
			q++;
		end
		if (q == (64'd1 << 24)) begin
			q = q >> 1;
			e++;
		end
		return {sgn, 8'(127 + e), q[22:0]};
	endfunction

	function automatic logic [31:0] format_code(input int unsigned v);
		logic [31:0] q1;
		int          e1, sh;
		longint      m1, dif;
		if (mode == MODE_INT8) begin
			return 32'((v - 128) & 8'hFF);
		end
		if (mode == MODE_UNIT) begin
			return single_of(1'b0, v, 255);
		end
		// symmetric: v/127.5 rounded, then minus one rounded again
		if (v == 0) begin
			return 32'hBF800000;
		end
		q1  = single_of(1'b0, 2 * v, 255);
		e1  = int'(q1[30:23]) - 127;
		sh  = 23 - e1;
		m1  = longint'({1'b1, q1[22:0]});
		dif = m1 - (longint'(1) << sh);
		if (dif < 0) begin
			return single_of(1'b1, -dif, longint'(1) << sh);
		end
		return single_of(1'b0, dif, longint'(1) << sh);
	endfunction

	// ceil(k*d/s): first output index that samples source index k
	function automatic int unsigned first_output(input int unsigned k, input int unsigned d,
			input int unsigned s);
		return (k * d + s - 1) / s;
	endfunction

	task automatic predict_elements(input logic [PIX_W-1:0] px, input logic fs);
		int unsigned  row_lo, row_hi, col_lo, col_hi, n, nch;
		int unsigned  level [3];
		logic [31:0]  code [3];
		tensor_elem_t el;
		row_lo = 0;
		row_hi = 0;
		col_lo = 0;
		col_hi = 0;
		n = 0;
		if (fs) begin
			cur_col = 0;
			cur_row = 0;
		end
		if (src_w != 0 && src_h != 0 && dst_w != 0 && dst_h != 0) begin
			row_lo = first_output(cur_row, dst_h, src_h);
			row_hi = first_output(cur_row + 1, dst_h, src_h);
			col_lo = first_output(cur_col, dst_w, src_w);
			col_hi = first_output(cur_col + 1, dst_w, src_w);
			if (row_lo > dst_h) row_lo = dst_h;
			if (row_hi > dst_h) row_hi = dst_h;
			if (col_lo > dst_w) col_lo = dst_w;
			if (col_hi > dst_w) col_hi = dst_w;
		end
		level[0] = px[15:11] * 255 / 31;
		level[1] = px[10:5] * 255 / 63;
		level[2] = px[4:0] * 255 / 31;
		nch = (n_chan > MAX_CHANNELS) ? MAX_CHANNELS : n_chan;
		for (int c = 0; c < 3; c++) begin
			code[c] = (c < nch) ? format_code(level[c]) : 32'd0;
		end
		for (int unsigned oy = row_lo; oy < row_hi && n < ELEM_CAP; oy++) begin
			for (int unsigned ox = col_lo; ox < col_hi && n < ELEM_CAP; ox++) begin
				el.offset = 16'(((oy * dst_w + ox) * n_chan) & 16'hFFFF);
				el.red    = code[0];
				el.green  = code[1];
				el.blue   = code[2];
				el.last   = 1'b0;
				elem_q.push_back(el);
				n++;
			end
		end
		if (n > 0) begin
			elem_q[elem_q.size() - 1].last = 1'b1;
		end
		// raster advance with wrap
		if (cur_col + 1 >= src_w || cur_col >= 1023) begin
			cur_col = 0;
			if (cur_row + 1 >= src_h || cur_row >= 1023) cur_row = 0;
			else cur_row++;
		end else begin
			cur_col++;
		end
	endtask

	// source side: pop the next pixel when the slot is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_elements(s_tdata, s_tuser);
			end
			if (!s_tvalid || s_tready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_q[0].pixel;
					s_tuser  <= pixel_q[0].frame_start;
					void'(pixel_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// tensor side: random back-pressure, compare each beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		tensor_elem_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (elem_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat tdata=%h", m_tdata));
				end else begin
					want = elem_q.pop_front();
					if (m_tdata[15:0] !== want.offset)
						report_mismatch($sformatf("offset %h want %h",
							m_tdata[15:0], want.offset));
					if (m_tdata[47:16] !== want.red)
						report_mismatch($sformatf("red %h want %h @%h",
							m_tdata[47:16], want.red, want.offset));
					if (m_tdata[79:48] !== want.green)
						report_mismatch($sformatf("green %h want %h @%h",
							m_tdata[79:48], want.green, want.offset));
					if (m_tdata[111:80] !== want.blue)
						report_mismatch($sformatf("blue %h want %h @%h",
							m_tdata[111:80], want.blue, want.offset));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("tlast %b want %b @%h",
							m_tlast, want.last, want.offset));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// registers are written back to back, one per edge, only while idle
	task automatic set_config(input int unsigned sw, input int unsigned sh,
			input int unsigned dw, input int unsigned dh, input int unsigned ch,
			input out_mode_t md);
		cfg_reg_t    idx [6];
		int unsigned val [6];
		idx = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT,
			REG_DST_CHAN, REG_OUT_MODE};
		val = '{sw, sh, dw, dh, ch, int'(md)};
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= CFG_DATA_W'(val[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		src_w  = sw & 10'h3FF;
		src_h  = sh & 10'h3FF;
		dst_w  = dw & 8'hFF;
		dst_h  = dh & 8'hFF;
		n_chan = ch & 2'h3;
		mode   = int'(md);
	endtask

	task automatic queue_pixel(input logic [PIX_W-1:0] px, input logic fs);
		pixel_beat_t b;
		b.pixel       = px;
		b.frame_start = fs;
		pixel_q.push_back(b);
	endtask

	// wait for the phase to drain, then let the front finish any silent pixel
	task automatic drain();
		while (pixel_q.size() != 0 || s_tvalid || elem_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		arst_n    = 1'b0;
		n_errors  = 0;
		stall_cycles  = 0;
		send_idle_pct = 9;
		recv_idle_pct = 84;
		// reset values of the block
		src_w   = 320;
		src_h   = 240;
		dst_w   = 128;
		dst_h   = 128;
		n_chan  = 3;
		mode    = MODE_INT8;
		cur_col = 0;
		cur_row = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: field extremes, mid-frame restart
		queue_pixel(16'h0000, 1'b1);
		queue_pixel(16'hFFFF, 1'b0);
		queue_pixel(16'hF800, 1'b0);
		queue_pixel(16'h07E0, 1'b1);
		queue_pixel(16'h001F, 1'b0);
		queue_pixel(16'h0821, 1'b0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			int unsigned nitems;
			// sender eager, receiver slow; then swapped; then full rate
			if (ph < 4) begin
				send_idle_pct = 9;
				recv_idle_pct = 84;
			end else if (ph < 7) begin
				send_idle_pct = 84;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			nitems = 16;
			case (ph)
				0: begin // heavy upscale, 64 elements a pixel
					set_config(16, 16, 128, 128, 3, MODE_UNIT);
				end
				1: begin // largest source to a single element
					set_config(1023, 1023, 1, 1, 1, MODE_SYM);
					nitems = 8;
				end
				2: begin // plain downscale
					set_config(16, 16, 8, 8, 2, MODE_INT8);
					nitems = 40;
				end
				3: begin // zero channels, mode three
					set_config(17, 16, 20, 3, 0, MODE_SYM3);
				end
				4: begin // zero destination width: nothing emitted
					set_config(16, 16, 0, 5, 3, MODE_UNIT);
					nitems = 6;
				end
				5: begin // register maximum: element cap per pixel
					set_config(16, 16, 255, 255, 3, MODE_SYM);
					nitems = 6;
				end
				6: begin // zero source size
					set_config(0, 0, 4, 4, 3, MODE_INT8);
					nitems = 4;
				end
				default: begin
					set_config($urandom_range(16, 24), $urandom_range(16, 24),
						$urandom_range(1, 32), $urandom_range(1, 32),
						$urandom_range(1, 3), out_mode_t'($urandom_range(0, 2)));
					nitems = 20;
				end
			endcase
			// mostly whole raster runs, occasional early frame restart
			for (int i = 0; i < nitems; i++) begin
				queue_pixel(16'($urandom), (i == 0) || ($urandom_range(99) < 4));
			end
			drain();
		end

		if (elem_q.size() != 0) begin
			report_mismatch($sformatf("%0d elements never arrived", elem_q.size()));
		end
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
